### rtl/base64url_stream_decoder_macros.svh
// Assertion helpers for the base64url stream decoder.
// All checks sample on the rising edge of i_clk and are ignored while reset is low.
`ifndef BASE64URL_STREAM_DECODER_MACROS_SVH
`define BASE64URL_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge
`define B64U_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define B64U_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define B64U_ASSERT_ALWAYS(lbl, expr, msg)
`define B64U_ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

### rtl/b64u_pkg.sv
package b64u_pkg;

    // default output limit and queue depth
    localparam int OUT_LIMIT_DEF   = 8192;
    localparam int QUEUE_DEPTH_DEF = 4;

    // widths fixed by the stream fields
    localparam int CHAR_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 14;
    localparam int SEXTET_W = 6;
    localparam int BUF_W    = 18;
    localparam int GROUP_W  = 24;

    localparam logic [LIMIT_W-1:0] MAX_BYTES_RST = 14'd8192;

    // character codes
    localparam logic [CHAR_W-1:0] CH_PAD    = 8'h3D;  // '='
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;  // '_'
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG_9  = 8'h39;

    localparam logic [SEXTET_W-1:0] SEXTET_DASH   = 6'd62;
    localparam logic [SEXTET_W-1:0] SEXTET_USCORE = 6'd63;
    localparam logic [SEXTET_W-1:0] SEXTET_LO_OFS = 6'd26;
    localparam logic [SEXTET_W-1:0] SEXTET_DG_OFS = 6'd52;

    // one queued command: up to three result words
    typedef struct packed {
        logic [GROUP_W-1:0] data;    // first byte in the top bits
        logic [1:0]         count;   // words to send, 1..3
        logic               bvalid;  // words carry decoded bytes
        logic               last;    // final word ends the string
        logic               err;     // overflow error word
    } t_cmd;

    // alphabet lookup; unknown characters map to zero
    function automatic logic [SEXTET_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + {2'b00, SEXTET_LO_OFS};
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            d = c - CH_DIG_0 + {2'b00, SEXTET_DG_OFS};
        end else if (c == CH_DASH) begin
            d = {2'b00, SEXTET_DASH};
        end else if (c == CH_USCORE) begin
            d = {2'b00, SEXTET_USCORE};
        end
        return d[SEXTET_W-1:0];
    endfunction

endpackage

### rtl/b64u_front.sv
module b64u_front #(
    parameter int OUT_LIMIT = b64u_pkg::OUT_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [b64u_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [b64u_pkg::CHAR_W-1:0]  i_s_tdata,
    input  logic                         i_s_tlast,
    input  logic                         i_q_ready,
    output logic                         o_push,
    output b64u_pkg::t_cmd               o_cmd
);

    localparam int LW = 17;
    localparam logic [LW-1:0] LIM_CAP = LW'(OUT_LIMIT);

    logic [b64u_pkg::BUF_W-1:0]   r_buf,     n_buf;
    logic [1:0]                   r_cnt,     n_cnt;
    logic [b64u_pkg::LIMIT_W-1:0] r_emitted, n_emitted;
    logic                         r_drop,    n_drop;
    logic [b64u_pkg::LIMIT_W-1:0] r_max;

    logic                         accept;
    logic                         skip;
    logic [b64u_pkg::SEXTET_W-1:0] sx;
    logic                         full;
    logic [b64u_pkg::BUF_W-1:0]   buf_after;
    logic [1:0]                   cnt_after;
    logic [1:0]                   nb;
    logic [b64u_pkg::GROUP_W-1:0] grp;
    logic [LW-1:0]                limit_now;
    logic [LW-1:0]                sum;
    logic                         over;

    assign accept     = i_s_tvalid && i_q_ready;
    assign o_s_tready = i_q_ready;

    // classify the character
    assign skip = (i_s_tdata == b64u_pkg::CH_PAD) || (i_s_tdata == b64u_pkg::CH_SPACE) ||
                  (i_s_tdata == b64u_pkg::CH_LF)  || (i_s_tdata == b64u_pkg::CH_CR);
    assign sx   = b64u_pkg::sextet_of(i_s_tdata);
    assign full = !skip && (r_cnt == 2'd3);

    assign buf_after = skip ? r_buf : {r_buf[b64u_pkg::BUF_W-b64u_pkg::SEXTET_W-1:0], sx};
    assign cnt_after = skip ? r_cnt : r_cnt + 2'd1;

    // bytes produced by this character: full group or end-of-string tail
    always_comb begin
        nb  = 2'd0;
        grp = '0;
        if (full) begin
            nb  = 2'd3;
            grp = {r_buf, sx};
        end else if (i_s_tlast && cnt_after == 2'd2) begin
            nb  = 2'd1;
            grp = {buf_after[11:4], 16'h0000};
        end else if (i_s_tlast && cnt_after == 2'd3) begin
            nb  = 2'd2;
            grp = {buf_after[17:10], buf_after[9:2], 8'h00};
        end
    end

    // all-or-nothing limit check
    assign limit_now = ({3'b000, r_max} > LIM_CAP) ? LIM_CAP : {3'b000, r_max};
    assign sum       = {3'b000, r_emitted} + {15'd0, nb};
    assign over      = (nb != 2'd0) && (sum > limit_now);

    // command for the back end
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept && !r_drop) begin
            if (over) begin
                o_push       = 1'b1;
                o_cmd.count  = 2'd1;
                o_cmd.last   = 1'b1;
                o_cmd.err    = 1'b1;
            end else if (nb != 2'd0) begin
                o_push       = 1'b1;
                o_cmd.data   = grp;
                o_cmd.count  = nb;
                o_cmd.bvalid = 1'b1;
                o_cmd.last   = i_s_tlast;
            end else if (i_s_tlast) begin
                o_push       = 1'b1;
                o_cmd.count  = 2'd1;
                o_cmd.last   = 1'b1;
            end
        end
    end

    // string state update
    always_comb begin
        n_buf     = r_buf;
        n_cnt     = r_cnt;
        n_emitted = r_emitted;
        n_drop    = r_drop;
        if (accept) begin
            if (r_drop) begin
                // discard until end of string
            end else if (over) begin
                n_buf  = '0;
                n_cnt  = 2'd0;
                n_drop = 1'b1;
            end else begin
                n_buf     = full ? '0 : buf_after;
                n_cnt     = full ? 2'd0 : cnt_after;
                n_emitted = sum[b64u_pkg::LIMIT_W-1:0];
            end
            if (i_s_tlast) begin
                n_buf     = '0;
                n_cnt     = 2'd0;
                n_emitted = '0;
                n_drop    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf     <= '0;
            r_cnt     <= 2'd0;
            r_emitted <= '0;
            r_drop    <= 1'b0;
            r_max     <= b64u_pkg::MAX_BYTES_RST;
        end else begin
            r_buf     <= n_buf;
            r_cnt     <= n_cnt;
            r_emitted <= n_emitted;
            r_drop    <= n_drop;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

endmodule

### rtl/b64u_queue.sv
module b64u_queue #(
    parameter int DEPTH = b64u_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64u_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output b64u_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64u_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### rtl/b64u_back.sv
module b64u_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  b64u_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [b64u_pkg::BYTE_W-1:0] o_m_tdata,
    output logic                        o_m_tlast,
    output logic [1:0]                  o_m_tuser
);

    logic                         r_busy, n_busy;
    logic [1:0]                   r_left, n_left;
    logic [b64u_pkg::GROUP_W-1:0] r_data, n_data;
    logic                         r_bv,   n_bv;
    logic                         r_last, n_last;
    logic                         r_err,  n_err;
    logic                         final_word;
    logic                         take;

    assign final_word = (r_left == 2'd1);
    assign take = i_q_valid && (!r_busy || (i_m_tready && final_word));
    assign o_pop = take;

    // output word
    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = r_data[b64u_pkg::GROUP_W-1 -: b64u_pkg::BYTE_W];
    assign o_m_tlast  = r_last && final_word;
    assign o_m_tuser  = {r_err, r_bv};

    // load a command or step to its next byte
    always_comb begin
        n_busy = r_busy;
        n_left = r_left;
        n_data = r_data;
        n_bv   = r_bv;
        n_last = r_last;
        n_err  = r_err;
        if (take) begin
            n_busy = 1'b1;
            n_left = i_cmd.count;
            n_data = i_cmd.data;
            n_bv   = i_cmd.bvalid;
            n_last = i_cmd.last;
            n_err  = i_cmd.err;
        end else if (r_busy && i_m_tready) begin
            if (final_word) begin
                n_busy = 1'b0;
            end else begin
                n_left = r_left - 2'd1;
                n_data = {r_data[b64u_pkg::GROUP_W-b64u_pkg::BYTE_W-1:0],
                          {b64u_pkg::BYTE_W{1'b0}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_bv   <= n_bv;
        r_last <= n_last;
        r_err  <= n_err;
    end

endmodule

### rtl/base64url_stream_decoder.sv
// URL-safe base64 stream decoder, lenient.
// Slave channel: one character per word on i_s_tdata, i_s_tlast on the last
// character of a string. Master channel: one decoded byte per word on
// o_m_tdata, o_m_tuser = {overflow_error, byte_valid}, o_m_tlast closes a string.
// Config: i_cfg_we with i_cfg_wdata sets the per-string byte limit
// (reset 8192, capped at OUT_LIMIT); write it only while the block is idle.
// Throughput: one character per cycle while the queue has room. A character
// that completes a group queues three bytes, sent one per cycle by the output
// serializer while the receiver is ready; four characters give three bytes, so
// the output port keeps up on average. A character's command is written to the
// queue, then loaded into the serializer's output register; further bytes follow.
// A small command queue (QUEUE_DEPTH entries) sits between the decoder front
// and the serializer; when the receiver stalls, the queue fills and
// o_s_tready drops until there is room again.
// An over-limit group yields a single error word and the rest of the string
// is dropped without output. Reset clears the string state, the queue and the
// output register, and restores the default limit.
`include "base64url_stream_decoder_macros.svh"

module base64url_stream_decoder #(
    parameter int OUT_LIMIT   = b64u_pkg::OUT_LIMIT_DEF,
    parameter int QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [b64u_pkg::LIMIT_W-1:0] i_cfg_wdata,  // max_output_bytes
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [b64u_pkg::CHAR_W-1:0]  i_s_tdata,    // char_code
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [b64u_pkg::BYTE_W-1:0]  o_m_tdata,    // data_byte
    output logic                         o_m_tlast,
    output logic [1:0]                   o_m_tuser     // [0] byte_valid, [1] overflow_error
);

    logic           q_push;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    b64u_pkg::t_cmd push_cmd;
    b64u_pkg::t_cmd head_cmd;

    // decode and limit check
    b64u_front #(
        .OUT_LIMIT (OUT_LIMIT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_q_ready   (q_ready),
        .o_push      (q_push),
        .o_cmd       (push_cmd)
    );

    // command queue
    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // byte serializer
    b64u_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_cmd      (head_cmd),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // checks
    `B64U_ASSERT_IMPLIES(a_err_word_final, o_m_tvalid && o_m_tuser[1], o_m_tlast && !o_m_tuser[0], "error word must be final and carry no byte")
    `B64U_ASSERT_IMPLIES(a_nobyte_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0, "word without byte must have zero data")
    `B64U_ASSERT_IMPLIES(a_push_room, q_push, q_ready, "command pushed into a full queue")

endmodule

### test/testbench.sv
module testbench;
    import b64u_pkg::*;

    // one character word waiting to be sent
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              eos;
        int unsigned       gap;
    } t_char_item;

    // one decoded result word
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              bvalid;
        logic              last;
        logic              err;
    } t_dec_word;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wdata = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [CHAR_W-1:0]   i_s_tdata   = '0;
    logic                i_s_tlast   = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [BYTE_W-1:0]   o_m_tdata;
    logic                o_m_tlast;
    logic [1:0]          o_m_tuser;

    t_char_item char_q[$];
    t_dec_word  byte_q[$];
    int         fail_cnt = 0;
    bit         tx_quiet = 1'b0;
    bit         rx_quiet = 1'b0;

    // decoder state as predicted
    logic [LIMIT_W-1:0] lim_reg   = MAX_BYTES_RST;
    logic [BUF_W-1:0]   dec_buf   = '0;
    int                 dec_count = 0;
    int                 dec_emit  = 0;
    bit                 dec_drop  = 1'b0;

    base64url_stream_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic clear_string_state();
        dec_buf   = '0;
        dec_count = 0;
        dec_emit  = 0;
        dec_drop  = 1'b0;
    endtask

    task automatic push_word(logic [BYTE_W-1:0] data, logic bv, logic last, logic err);
        t_dec_word w;
        w.data   = data;
        w.bvalid = bv;
        w.last   = last;
        w.err    = err;
        byte_q.push_back(w);
    endtask

    // expected words for one accepted character
    task automatic decode_char(input logic [CHAR_W-1:0] ch, input logic eos);
        logic [SEXTET_W-1:0] sx;
        logic [GROUP_W-1:0]  grp;
        logic [BYTE_W-1:0]   outb [3];
        int                  nb;
        int                  cap;
        nb = 0;
        if (dec_drop) begin
            if (eos) clear_string_state();
            return;
        end
        if (!(ch == CH_PAD || ch == CH_SPACE || ch == CH_CR || ch == CH_LF)) begin
            if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
                sx = 6'(ch - CH_UP_A);
            end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
                sx = 6'(ch - CH_LO_A + 26);
            end else if (ch >= CH_DIG_0 && ch <= CH_DIG_9) begin
                sx = 6'(ch - CH_DIG_0 + 52);
            end else if (ch == CH_DASH) begin
                sx = 6'd62;
            end else if (ch == CH_USCORE) begin
                sx = 6'd63;
            end else begin
                sx = '0;
            end
            if (dec_count == 3) begin
                grp     = {dec_buf, sx};
                outb[0] = grp[23:16];
                outb[1] = grp[15:8];
                outb[2] = grp[7:0];
                nb      = 3;
                dec_buf   = '0;
                dec_count = 0;
            end else begin
                dec_buf   = {dec_buf[BUF_W-SEXTET_W-1:0], sx};
                dec_count = dec_count + 1;
            end
        end
        // tail bytes at end of string
        if (eos && nb == 0) begin
            if (dec_count == 2) begin
                outb[0] = dec_buf[11:4];
                nb = 1;
            end else if (dec_count == 3) begin
                outb[0] = dec_buf[17:10];
                outb[1] = dec_buf[9:2];
                nb = 2;
            end
        end
        cap = (lim_reg > OUT_LIMIT_DEF) ? OUT_LIMIT_DEF : int'(lim_reg);
        // all-or-nothing limit check
        if (nb > 0 && dec_emit + nb > cap) begin
            push_word('0, 1'b0, 1'b1, 1'b1);
            if (eos) begin
                clear_string_state();
            end else begin
                dec_buf   = '0;
                dec_count = 0;
                dec_drop  = 1'b1;
            end
            return;
        end
        if (nb == 0) begin
            if (eos) begin
                push_word('0, 1'b0, 1'b1, 1'b0);
                clear_string_state();
            end
            return;
        end
        for (int i = 0; i < nb; i++) begin
            push_word(outb[i], 1'b1, eos && (i == nb - 1), 1'b0);
        end
        dec_emit = dec_emit + nb;
        if (eos) clear_string_state();
    endtask

    // sender: feeds character words from char_q
    always @(posedge i_clk) begin : drv_proc
        logic        nxt_valid;
        t_char_item  cur;
        int unsigned tx_wait;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            nxt_valid = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                decode_char(i_s_tdata, i_s_tlast);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && char_q.size() != 0) begin
                if (tx_wait < char_q[0].gap) begin
                    tx_wait++;
                end else begin
                    cur = char_q.pop_front();
                    i_s_tdata <= cur.ch;
                    i_s_tlast <= cur.eos;
                    nxt_valid = 1'b1;
                    tx_wait   = 0;
                end
            end
            i_s_tvalid <= nxt_valid;
        end
    end

    // receiver: checks each result word against the oldest expectation
    always @(posedge i_clk) begin : mon_proc
        t_dec_word   want;
        int unsigned rx_wait;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (byte_q.size() == 0) begin
                    $error("unexpected word: data %0h user %0b last %0b",
                           o_m_tdata, o_m_tuser, o_m_tlast);
                    fail_cnt++;
                end else begin
                    want = byte_q.pop_front();
                    if (o_m_tdata !== want.data) begin
                        $error("data_byte: expected %0h, got %0h", want.data, o_m_tdata);
                        fail_cnt++;
                    end
                    if (o_m_tuser[0] !== want.bvalid) begin
                        $error("byte_valid: expected %0b, got %0b", want.bvalid, o_m_tuser[0]);
                        fail_cnt++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_m_tlast);
                        fail_cnt++;
                    end
                    if (o_m_tuser[1] !== want.err) begin
                        $error("overflow_error: expected %0b, got %0b", want.err, o_m_tuser[1]);
                        fail_cnt++;
                    end
                end
                rx_wait = draw_wait(rx_quiet);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_m_tready <= (rx_wait == 0);
        end
    end

    task automatic push_char(logic [CHAR_W-1:0] ch, logic eos);
        t_char_item it;
        it.ch  = ch;
        it.eos = eos;
        it.gap = draw_wait(tx_quiet);
        char_q.push_back(it);
    endtask

    // whole string, end flag on its final character
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [CHAR_W-1:0] enc_char(int unsigned v);
        if (v < 26) return 8'(CH_UP_A + v);
        if (v < 52) return 8'(CH_LO_A + v - 26);
        if (v < 62) return 8'(CH_DIG_0 + v - 52);
        return (v == 62) ? CH_DASH : CH_USCORE;
    endfunction

    // mostly alphabet, some skipped codes, some arbitrary bytes
    function automatic logic [CHAR_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return enc_char($urandom_range(0, 63));
        if (r < 90) begin
            case ($urandom_range(0, 3))
                0: return CH_PAD;
                1: return CH_SPACE;
                2: return CH_CR;
                default: return CH_LF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // wait until sender and receiver are both idle
    task automatic drain();
        while (char_q.size() != 0 || i_s_tvalid || byte_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        lim_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stim_proc
        logic [LIMIT_W-1:0] limits [10];
        int                 n;
        int                 len;
        limits = '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4, 14'd5,
                   14'($urandom_range(6, 30)), 14'd16383, 14'd8191, 14'd8193};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: alphabet ends, skipped codes, odd codes, tails
        push_text("AZaz09-_");
        push_char("A", 1'b0);
        push_char("B", 1'b0);
        push_char(CH_SPACE, 1'b0);
        push_char(CH_CR, 1'b0);
        push_char(CH_LF, 1'b0);
        push_char(CH_PAD, 1'b1);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_USCORE, 1'b1);
        push_char("Q", 1'b1);
        push_char(CH_PAD, 1'b1);
        drain();

        // directed: zero limit, overflow on final item and mid-string
        write_limit('0);
        push_text("AB");
        push_text("ABCDEF");
        drain();

        // random phases, the first with the limit left by the directed test
        for (int ph = -1; ph < 10; ph++) begin
            if (ph >= 0) write_limit(limits[ph]);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < 24) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 16);
                for (int i = 0; i < len; i++) begin
                    push_char(pick_char(), i == len - 1);
                end
                n += len;
            end
            drain();
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0 && byte_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
